>>> rtl/core/assert_macros.svh
// Assertion macros shared by the k-mer matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define KHWM_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a trigger on one edge is followed by a condition on the next.
`define KHWM_ASSERT_NEXT(name, trig, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) else $error(msg);

`endif

>>> rtl/core/khwm_pkg.sv
// Shared types and constants of the k-mer Hamming window matcher.
package khwm_pkg;

  localparam int WIN_W     = 64;
  localparam int BASE_W    = 2;
  localparam int KLEN_W    = 6;
  localparam int DIST_W    = 6;
  localparam int PCNT_W    = 3;
  localparam int PIDX_W    = 2;
  localparam int PAT_SLOTS = 4;
  localparam int CFG_IDX_W = 3;

  // Result queue holds whole items; one item may carry up to four matches.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MM    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT0      = 3'd3;

  // Register values after reset.
  localparam logic [KLEN_W-1:0] RST_KMER_LEN  = 6'd8;
  localparam logic [DIST_W-1:0] RST_MAX_MM    = 6'd2;
  localparam logic [PCNT_W-1:0] RST_PAT_COUNT = 3'd1;

  typedef logic [BASE_W-1:0] base_t;

  // One queued item: aligned window plus per-pattern hit flag and distance.
  typedef struct packed {
    logic [WIN_W-1:0]                   window;
    logic [PAT_SLOTS-1:0]               hit;
    logic [PAT_SLOTS-1:0][DIST_W-1:0]   dists;
  } rec_t;

endpackage

>>> rtl/core/khwm_cell.sv
// One window cell: holds a base and its per-pattern mismatch flags.
module khwm_cell #(
  parameter int IDX     = 0,
  parameter int MAX_LEN = 32,
  parameter int NUM_PAT = 4
) (
  input  logic                                   clk,
  input  logic                                   shift,
  input  khwm_pkg::base_t                        base_in,
  input  logic [khwm_pkg::KLEN_W-1:0]            kmer_len,
  input  logic [NUM_PAT-1:0][khwm_pkg::WIN_W-1:0] patterns,
  output khwm_pkg::base_t                        base_q,
  output logic [NUM_PAT-1:0]                     mismatch
);
  import khwm_pkg::*;

  logic [KLEN_W:0]      pos;
  logic                 in_win;
  logic [KLEN_W-2:0]    sel;
  logic [NUM_PAT-1:0]   mismatch_next;

  // Cell IDX lines up with pattern base IDX + k - MAX_LEN once inside the window.
  assign pos    = (KLEN_W+1)'(IDX) + {1'b0, kmer_len};
  assign in_win = pos >= (KLEN_W+1)'(MAX_LEN);
  assign sel    = (KLEN_W-1)'(pos - (KLEN_W+1)'(MAX_LEN));

  always_comb begin
    for (int p = 0; p < NUM_PAT; p++) begin
      mismatch_next[p] = in_win && (base_in != patterns[p][{sel, 1'b0} +: BASE_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      base_q   <= base_in;
      mismatch <= mismatch_next;
    end
  end

endmodule

>>> rtl/core/khwm_result_queue.sv
// Item queue that unpacks each queued item into one result per matching pattern.
module khwm_result_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  khwm_pkg::rec_t                rec,
  output logic [khwm_pkg::QCNT_W-1:0]   count,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [khwm_pkg::PIDX_W-1:0]   pattern_index,
  output logic [khwm_pkg::WIN_W-1:0]    window_bases,
  output logic [khwm_pkg::DIST_W-1:0]   mismatches,
  output logic                          last_match
);
  import khwm_pkg::*;

  rec_t                    mem [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr;
  logic [QPTR_W-1:0]       rd_ptr;
  logic [PAT_SLOTS-1:0]    done;
  rec_t                    head;
  logic [PAT_SLOTS-1:0]    rem;
  logic [PIDX_W-1:0]       cur;
  logic [PAT_SLOTS-1:0]    cur_bit;
  logic                    pop_xfer;
  logic                    pop;

  assign head = mem[rd_ptr];
  assign rem  = head.hit & ~done;

  // Lowest pending pattern goes first.
  always_comb begin
    cur = '0;
    for (int i = PAT_SLOTS - 1; i >= 0; i--) begin
      if (rem[i]) cur = PIDX_W'(i);
    end
  end

  assign cur_bit       = PAT_SLOTS'(1) << cur;
  assign result_valid  = count != '0;
  assign pattern_index = cur;
  assign window_bases  = head.window;
  assign mismatches    = head.dists[cur];
  assign last_match    = (rem & ~cur_bit) == '0;
  assign pop_xfer      = result_valid && !result_stall;
  assign pop           = pop_xfer && last_match;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      done   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
      if (pop) begin
        done <= '0;
      end else if (pop_xfer) begin
        done <= done | cur_bit;
      end
    end
  end

  `include "assert_macros.svh"

  `KHWM_ASSERT(a_no_push_full, !push || (count < QCNT_W'(QDEPTH)), "push into full queue")
  `KHWM_ASSERT(a_head_pending, !result_valid || (rem != '0), "queued item has no pending match")
  `KHWM_ASSERT_NEXT(a_done_clear, pop, done == '0, "pending mask not cleared after item drained")

endmodule

>>> rtl/core/kmer_hamming_window_matcher.sv
// Top level: streaming approximate k-mer matcher over a chain of window cells.
// Path: a matching base is registered in the cells and v0, then psum, win1 and v1, then the queue.
// Throughput: one base per cycle, results one per cycle (several per base in turn), unless stalled.
// Base intake stalls once queued items plus compares in flight reach the 4 queue slots.
// Reset (synchronous, rst high): config returns to k=8, limit 2, one pattern, patterns 0;
// fill count and result queue clear. The configuration port is always ready.
module kmer_hamming_window_matcher #(
  parameter int MAX_KMER_LEN = 32,
  parameter int NUM_PATTERNS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  // base stream
  input  logic                            item_valid,
  output logic                            item_stall,
  input  khwm_pkg::base_t                 base,
  input  logic                            seq_start,
  // match results
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [khwm_pkg::PIDX_W-1:0]     pattern_index,
  output logic [khwm_pkg::WIN_W-1:0]      window_bases,
  output logic [khwm_pkg::DIST_W-1:0]     mismatches,
  output logic                            last_match,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [khwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [khwm_pkg::WIN_W-1:0]      cfg_data
);
  import khwm_pkg::*;

  localparam int NGRP = (MAX_KMER_LEN + 7) / 8;
  localparam logic [KLEN_W-1:0] MAX_K   = KLEN_W'(MAX_KMER_LEN);
  localparam logic [PCNT_W-1:0] NUM_PAT = PCNT_W'(NUM_PATTERNS);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [KLEN_W-1:0]                        kmer_length;
  logic [DIST_W-1:0]                        max_mismatches;
  logic [PCNT_W-1:0]                        pattern_count;
  logic [NUM_PATTERNS-1:0][WIN_W-1:0]       patterns;
  logic                                     cfg_xfer;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length    <= RST_KMER_LEN;
      max_mismatches <= RST_MAX_MM;
      pattern_count  <= RST_PAT_COUNT;
      patterns       <= '0;
    end else if (cfg_xfer) begin
      case (cfg_index)
        CFG_KMER_LEN:  kmer_length    <= cfg_data[KLEN_W-1:0];
        CFG_MAX_MM:    max_mismatches <= cfg_data[DIST_W-1:0];
        CFG_PAT_COUNT: pattern_count  <= cfg_data[PCNT_W-1:0];
        default: begin
          // pattern slots; indexes past the implemented slots drop the write
          for (int p = 0; p < NUM_PATTERNS; p++) begin
            if (cfg_index == CFG_IDX_W'(int'(CFG_PAT0) + p)) patterns[p] <= cfg_data;
          end
        end
      endcase
    end
  end

  // Clamp k into 1..MAX_KMER_LEN and the pattern count into 0..NUM_PATTERNS.
  logic [KLEN_W-1:0] k_eff;
  logic [PCNT_W-1:0] active;

  always_comb begin
    if (kmer_length == '0)        k_eff = KLEN_W'(1);
    else if (kmer_length > MAX_K) k_eff = MAX_K;
    else                          k_eff = kmer_length;
  end

  assign active = (pattern_count > NUM_PAT) ? NUM_PAT : pattern_count;

  // ---------------------------------------------------------------------------
  // Intake and fill count
  // ---------------------------------------------------------------------------
  logic                  item_xfer;
  logic [KLEN_W-1:0]     fill_count;
  logic [KLEN_W-1:0]     fill_count_next;
  logic [QCNT_W-1:0]     q_count;
  logic                  v0;
  logic                  v1;

  assign item_xfer = item_valid && !item_stall;

  // Hold intake while every queue slot is spoken for by queued or in-flight items.
  assign item_stall = ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(v0) + (QCNT_W+1)'(v1))
                      >= (QCNT_W+1)'(QDEPTH);

  always_comb begin
    if (seq_start)              fill_count_next = KLEN_W'(1);
    else if (fill_count < MAX_K) fill_count_next = fill_count + KLEN_W'(1);
    else                        fill_count_next = fill_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      v0         <= 1'b0;
    end else begin
      if (item_xfer) fill_count <= fill_count_next;
      // stage 0 holds a compare only when the window carries k bases of this sequence
      v0 <= item_xfer && (fill_count_next >= k_eff);
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain: cell MAX_KMER_LEN-1 takes the new base, each cell hands its
  // base down to the next lower one, and every cell flags per-pattern mismatch.
  // ---------------------------------------------------------------------------
  base_t                    cell_base [MAX_KMER_LEN];
  logic [NUM_PATTERNS-1:0]  cell_mm   [MAX_KMER_LEN];
  base_t                    base_q_w  [MAX_KMER_LEN];

  for (genvar j = 0; j < MAX_KMER_LEN; j++) begin : g_cell
    base_t feed;
    if (j == MAX_KMER_LEN - 1) begin : g_head
      assign feed = base;
    end else begin : g_link
      assign feed = cell_base[j+1];
    end

    khwm_cell #(
      .IDX     (j),
      .MAX_LEN (MAX_KMER_LEN),
      .NUM_PAT (NUM_PATTERNS)
    ) u_cell (
      .clk      (clk),
      .shift    (item_xfer),
      .base_in  (feed),
      .kmer_len (k_eff),
      .patterns (patterns),
      .base_q   (base_q_w[j]),
      .mismatch (cell_mm[j])
    );

    assign cell_base[j] = base_q_w[j];
  end

  // ---------------------------------------------------------------------------
  // Stage 1: group popcounts and window alignment
  // ---------------------------------------------------------------------------
  logic [2*MAX_KMER_LEN-1:0]                    cells_flat;
  logic [NUM_PATTERNS-1:0][NGRP*8-1:0]          mm_pad;
  logic [KLEN_W:0]                              shamt;
  logic [WIN_W-1:0]                             win_next;
  logic [WIN_W-1:0]                             win1;
  logic [NUM_PATTERNS-1:0][NGRP-1:0][3:0]       psum_next;
  logic [NUM_PATTERNS-1:0][NGRP-1:0][3:0]       psum;

  always_comb begin
    mm_pad = '0;
    for (int j = 0; j < MAX_KMER_LEN; j++) begin
      cells_flat[2*j +: BASE_W] = cell_base[j];
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        mm_pad[p][j] = cell_mm[j][p];
      end
    end
  end

  // Keep the newest k bases, oldest of them in the low bits, zeros above.
  assign shamt    = {MAX_K - k_eff, 1'b0};
  assign win_next = WIN_W'(cells_flat) >> shamt;

  always_comb begin
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      for (int g = 0; g < NGRP; g++) begin
        logic [3:0] acc;
        acc = '0;
        for (int b = 0; b < 8; b++) begin
          acc = acc + 4'(mm_pad[p][g*8+b]);
        end
        psum_next[p][g] = acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (v0) begin
      psum <= psum_next;
      win1 <= win_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: final distance, limit compare, queue push
  // ---------------------------------------------------------------------------
  rec_t  rec;
  logic  push;

  always_comb begin
    rec        = '0;
    rec.window = win1;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      logic [DIST_W-1:0] d;
      d = '0;
      for (int g = 0; g < NGRP; g++) begin
        d = d + DIST_W'(psum[p][g]);
      end
      rec.dists[p] = d;
      rec.hit[p]   = v1 && (PCNT_W'(p) < active) && (d <= max_mismatches);
    end
  end

  // Drop items with no hit; they produce no result.
  assign push = v1 && (rec.hit != '0);

  khwm_result_queue u_queue (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .rec           (rec),
    .count         (q_count),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .pattern_index (pattern_index),
    .window_bases  (window_bases),
    .mismatches    (mismatches),
    .last_match    (last_match)
  );

  `include "assert_macros.svh"

  `KHWM_ASSERT(a_inflight_bound,
    ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(v0) + (QCNT_W+1)'(v1)) <= (QCNT_W+1)'(QDEPTH),
    "queued plus in-flight items exceed queue depth")

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the k-mer Hamming window matcher.
`timescale 1ns / 1ps

module tb_top;
  import khwm_pkg::*;

  // Index past the last register: a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
  localparam int KMAX = 32;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [PIDX_W-1:0] idx;
    logic [WIN_W-1:0]  win;
    logic [DIST_W-1:0] mm;
    logic              last;
  } match_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  base_t                base;
  logic                 seq_start;
  logic                 result_valid;
  logic                 result_stall;
  logic [PIDX_W-1:0]    pattern_index;
  logic [WIN_W-1:0]     window_bases;
  logic [DIST_W-1:0]    mismatches;
  logic                 last_match;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WIN_W-1:0]     cfg_data;

  // Shadow copy of the block: registers, base history and fill count.
  logic [KLEN_W-1:0]    shadow_klen;
  logic [DIST_W-1:0]    shadow_limit;
  logic [PCNT_W-1:0]    shadow_pcount;
  logic [WIN_W-1:0]     shadow_pattern [PAT_SLOTS];
  logic [WIN_W-1:0]     shadow_window;
  logic [KLEN_W-1:0]    shadow_fill;

  match_t expected_matches[$];
  int     error_count = 0;
  bit     tx_idle_on = 1'b1;
  bit     rx_idle_on = 1'b1;
  int     rx_hold_cycles = 0;

  kmer_hamming_window_matcher i_dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .base          (base),
    .seq_start     (seq_start),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .pattern_index (pattern_index),
    .window_bases  (window_bases),
    .mismatches    (mismatches),
    .last_match    (last_match),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Effective k: zero reads as one, anything past the window saturates.
  function automatic int active_klen();
    if (shadow_klen == 0) return 1;
    if (shadow_klen > KMAX) return KMAX;
    return int'(shadow_klen);
  endfunction

  // Shift one base into the shadow window and queue every pattern hit it causes.
  task automatic predict_matches(input base_t b, input logic start);
    match_t      hits [PAT_SLOTS];
    int          n;
    int          k;
    int          act;
    int          ndiff;
    logic [63:0] mask;
    logic [63:0] aligned;
    n = 0;
    shadow_window = {b, shadow_window[WIN_W-1:BASE_W]};
    if (start) shadow_fill = KLEN_W'(1);
    else if (shadow_fill < KMAX) shadow_fill = shadow_fill + 1'b1;
    k = active_klen();
    if (shadow_fill < k) return;
    act = (shadow_pcount > PAT_SLOTS) ? PAT_SLOTS : int'(shadow_pcount);
    mask = (k == KMAX) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
    // Align so the oldest base of the k-window sits in the low bits.
    aligned = (shadow_window >> (WIN_W - 2 * k)) & mask;
    for (int i = 0; i < act; i++) begin
      ndiff = 0;
      for (int j = 0; j < k; j++)
        if (aligned[2*j +: 2] != shadow_pattern[i][2*j +: 2]) ndiff++;
      if (ndiff <= shadow_limit) begin
        hits[n].idx  = PIDX_W'(i);
        hits[n].win  = aligned;
        hits[n].mm   = DIST_W'(ndiff);
        hits[n].last = 1'b0;
        n++;
      end
    end
    for (int m = 0; m < n; m++) begin
      hits[m].last = (m == n - 1);
      expected_matches.push_back(hits[m]);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t MISMATCH %s: expected %h, got %h", $time, what, want, got);
    error_count++;
  endtask

  // Offer one base, after a random gap if tx_idle_on is set; return at the edge of its transfer.
  task automatic send_base(input base_t b, input logic start);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    base       <= b;
    seq_start  <= start;
    do @(posedge clk); while (item_stall);
    predict_matches(b, start);
  endtask

  // One register transfer; mirror it into the shadow registers.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_KMER_LEN:  shadow_klen   = data[KLEN_W-1:0];
      CFG_MAX_MM:    shadow_limit  = data[DIST_W-1:0];
      CFG_PAT_COUNT: shadow_pcount = data[PCNT_W-1:0];
      default: begin
        if (idx >= CFG_PAT0 && idx < CFG_PAT0 + PAT_SLOTS)
          shadow_pattern[idx - CFG_PAT0] = data;
      end
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering bases, wait out every queued match, then let result-less
  // bases clear the compare stages before anyone touches the registers.
  task automatic drain_matches();
    item_valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input int klen, input int limit, input int pcount);
    write_reg(CFG_KMER_LEN, 64'(klen));
    write_reg(CFG_MAX_MM, 64'(limit));
    write_reg(CFG_PAT_COUNT, 64'(pcount));
    for (int p = 0; p < PAT_SLOTS; p++)
      write_reg(CFG_IDX_W'(CFG_PAT0 + p), {$urandom, $urandom});
  endtask

  // Reset registers: k = 8, limit 2, only the all-A pattern active.
  task automatic test_reset_config();
    base_t seq [10] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd0, 2'd2, 2'd0, 2'd3};
    for (int i = 0; i < 10; i++) send_base(seq[i], i == 0);
    drain_matches();
  endtask

  // k of zero reads as one; a pattern count of seven saturates to four.
  task automatic test_single_base_kmer();
    write_reg(CFG_KMER_LEN, 64'd0);
    write_reg(CFG_MAX_MM, 64'd0);
    write_reg(CFG_PAT_COUNT, 64'd7);
    // Junk above the first base must not take part in the compare.
    for (int p = 0; p < PAT_SLOTS; p++)
      write_reg(CFG_IDX_W'(CFG_PAT0 + p),
                {$urandom, 30'($urandom_range(0, 'h3fff_ffff)), 2'(p)});
    write_reg(CFG_NO_REG, '1);
    for (int b = 0; b < 4; b++) send_base(base_t'(b), b[0] == 1'b0);
    drain_matches();
  endtask

  task automatic test_no_active_patterns();
    write_reg(CFG_PAT_COUNT, 64'd0);
    send_base(2'd3, 1'b1);
    send_base(2'd0, 1'b0);
    send_base(2'd2, 1'b0);
    drain_matches();
  endtask

  // A new sequence must gate matching until k of its own bases have arrived.
  task automatic test_sequence_restart();
    base_t seq [6] = '{2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3};
    write_reg(CFG_KMER_LEN, 64'd3);
    write_reg(CFG_PAT_COUNT, 64'd1);
    write_reg(CFG_PAT0, 64'h39);
    for (int i = 0; i < 6; i++) send_base(seq[i], i == 3);
    drain_matches();
  endtask

  // Hold the result side for a long stretch while bases keep coming, so the
  // queue fills and the input stalls; every base here hits all four patterns.
  task automatic test_result_backpressure();
    write_config(1, 63, 4);
    tx_idle_on     = 1'b0;
    rx_hold_cycles = 80;
    for (int i = 0; i < 24; i++) send_base(base_t'($urandom_range(0, 3)), i == 0);
    drain_matches();
    tx_idle_on = 1'b1;
  endtask

  // Mostly copies of a configured pattern with sparse base errors, mixed with
  // random filler and sequence restarts, some of them inside a copy.
  task automatic run_random_phase(input int klen, input int limit, input int pcount,
                                  input int n_items);
    int    sent;
    int    sel;
    int    k;
    int    act;
    int    p;
    base_t b;
    sent = 0;
    write_config(klen, limit, pcount);
    k = active_klen();
    act = (shadow_pcount > PAT_SLOTS) ? PAT_SLOTS : int'(shadow_pcount);
    while (sent < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        p = (act > 0) ? $urandom_range(0, act - 1) : $urandom_range(0, PAT_SLOTS - 1);
        for (int j = 0; j < k; j++) begin
          b = shadow_pattern[p][2*j +: 2];
          if ($urandom_range(0, 7) == 0) b = base_t'($urandom_range(0, 3));
          send_base(b, $urandom_range(0, 39) == 0);
          sent++;
        end
      end else if (sel < 85) begin
        repeat ($urandom_range(1, 6)) begin
          send_base(base_t'($urandom_range(0, 3)), 1'b0);
          sent++;
        end
      end else begin
        send_base(base_t'($urandom_range(0, 3)), 1'b1);
        sent++;
      end
    end
    drain_matches();
  endtask

  task automatic test_random_sequences();
    int k;
    // Back to back on both sides for the first stretch.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random_phase(1, 0, 4, 40);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_random_phase(32, $urandom_range(0, 6), 2, 50);
    // Saturating k and an unlimited distance: every active pattern matches.
    run_random_phase(63, 32, 7, 30);
    repeat (4) begin
      k = $urandom_range(0, 10);
      run_random_phase(k, $urandom_range(0, k / 2 + 1), $urandom_range(0, 7), 25);
    end
  endtask

  // Receiver: draw a wait after each result transfer while rx_idle_on is set, or serve a long hold.
  initial begin
    int hold;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      hold = 0;
      if (rx_hold_cycles != 0) begin
        hold = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else if (!rst && result_valid && !result_stall && rx_idle_on) begin
        hold = $urandom_range(0, 10);
      end
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Compare every result transfer against the oldest queued match.
  always @(posedge clk) begin
    match_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_matches.size() == 0) begin
        report_mismatch("result with none queued", '0, window_bases);
      end else begin
        want = expected_matches.pop_front();
        if (pattern_index !== want.idx)
          report_mismatch("pattern_index", 64'(want.idx), 64'(pattern_index));
        if (window_bases !== want.win)
          report_mismatch("window_bases", want.win, window_bases);
        if (mismatches !== want.mm)
          report_mismatch("mismatches", 64'(want.mm), 64'(mismatches));
        if (last_match !== want.last)
          report_mismatch("last_match", 64'(want.last), 64'(last_match));
      end
    end
  end

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    base       = '0;
    seq_start  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    shadow_klen   = RST_KMER_LEN;
    shadow_limit  = RST_MAX_MM;
    shadow_pcount = RST_PAT_COUNT;
    for (int p = 0; p < PAT_SLOTS; p++) shadow_pattern[p] = '0;
    shadow_window = '0;
    shadow_fill   = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_config();
    test_single_base_kmer();
    test_no_active_patterns();
    test_sequence_restart();
    test_result_backpressure();
    test_random_sequences();
    drain_matches();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hang guard, far past the slowest legal run.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/khwm_pkg.sv
rtl/core/khwm_cell.sv
rtl/core/khwm_result_queue.sv
rtl/core/kmer_hamming_window_matcher.sv
sim/tb_top.sv
